>>> rtl/xmr_pkg.sv
// xmr_pkg: shared types, codes and helpers for the XMODEM receiver.
// No dependencies; used by xmodem_receiver_unit and xmr_res_fifo.
`default_nettype none
package xmr_pkg;

   // Request kinds carried in req_tuser
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_MODE    = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT = 3'd1;
   localparam logic [2:0] CSR_SYNC    = 3'd2;
   localparam logic [2:0] CSR_RETRANS = 3'd3;
   localparam logic [2:0] CSR_ERRORS  = 3'd4;

   // Line characters
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_G   = 8'h47;

   localparam logic [1:0] MODE_SUM = 2'd0;
   localparam logic [1:0] MODE_CRC = 2'd1;
   localparam logic [1:0] MODE_1K  = 2'd2;
   localparam logic [1:0] MODE_1KG = 2'd3;

   localparam logic [10:0] SHORT_BLOCK = 11'd128;
   localparam logic [10:0] LONG_BLOCK  = 11'd1024;
   localparam logic [23:0] TOTAL_MAX   = 24'hFFFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;

   // Packet events
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_NEW  = 2'd1;
   localparam logic [1:0] EV_DUP  = 2'd2;
   localparam logic [1:0] EV_REJ  = 2'd3;

   // Transfer status
   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_DONE    = 3'd1;
   localparam logic [2:0] ST_CANCEL  = 3'd2;
   localparam logic [2:0] ST_SYNC    = 3'd3;
   localparam logic [2:0] ST_RETRANS = 3'd4;
   localparam logic [2:0] ST_ERRORS  = 3'd5;

   typedef enum logic [3:0] {
      PH_IDLE, PH_SYNC, PH_CANWAIT, PH_BLKNO, PH_BLKCMP,
      PH_DATA, PH_CHK1, PH_CHK2, PH_FLUSH
   } phase_type;

   typedef enum logic [2:0] {
      AF_NONE, AF_NAK, AF_ACK_CANCEL, AF_CAN_SYNC, AF_CAN_RETRANS, AF_CAN_ERRORS
   } flush_type;

   // One result item
   typedef struct packed {
      logic [2:0]  status;
      logic [23:0] total_length;
      logic [10:0] block_length;
      logic [1:0]  packet_event;
      logic [9:0]  payload_index;
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic        last;
   } res_type;

   // CRC-16 update by one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> rtl/xmr_res_fifo.sv
// xmr_res_fifo: four-entry result queue, up to three pushes and one pop a cycle.
// Depends on xmr_pkg.
`default_nettype none
module xmr_res_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       push_n,
   input  wire xmr_pkg::res_type push_data [3],
   input  wire logic             pop,
   output xmr_pkg::res_type      head,
   output logic                  not_empty,
   output logic [2:0]            count
);

   xmr_pkg::res_type mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign do_pop    = pop && (cnt_ff != 3'd0);
   assign wr_in     = wr_ff + push_n;
   assign rd_in     = rd_ff + {1'b0, do_pop};
   assign cnt_in    = cnt_ff + {1'b0, push_n} - {2'b00, do_pop};
   assign head      = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != 3'd0);
   assign count     = cnt_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_n) begin
            mem_ff[wr_ff + 2'(i)] <= push_data[i];
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/xmodem_receiver_unit.sv
// xmodem_receiver_unit: XMODEM receiver top level (sum, CRC, 1K, 1K-G).
// Depends on xmr_pkg and xmr_res_fifo.
//
// Input channel req_*: req_tuser is the request kind (start, line byte,
// tick), req_tdata the line byte. Result channel rsp_*: control bytes to
// send, streamed payload bytes, block verdicts and transfer status; rsp_tlast
// marks the final result caused by one request (a request gives 0 to 3).
// Configuration csr_*: write enable, index and data;
// write only while the block is idle.
// Each request is handled in the cycle it is accepted: the protocol state
// updates at that edge and its results enter a four-entry result queue
// behind any results still held there.
// Throughput is one request per cycle while the queue drains; req_tready
// is high whenever the queue has room for three results (at most one
// held), so a request giving three CAN results stalls the requests behind it.
// Reset (synchronous) clears the queue, sets the registers to their
// defaults and leaves the protocol idle. If the result side stalls the
// queue fills, req_tready drops and no request is lost.
`default_nettype none
module xmodem_receiver_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // requests
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // tx_valid, tx_byte, payload_valid, payload_byte,
                                         // payload_index, packet_event, block_length,
                                         // total_length, status, zero pad
   output logic             rsp_tlast,   // last
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   // configuration registers
   logic [1:0]  mode_ff;
   logic [15:0] rto_ff;
   logic [7:0]  msync_ff, mretr_ff, merr_ff;

   // protocol state
   xmr_pkg::phase_type phase_ff, phase_in;
   xmr_pkg::flush_type af_ff, af_in;
   logic [7:0]  exp_ff, exp_in, got_ff, got_in;
   logic [10:0] cnt_ff, cnt_in;
   logic        long_ff, long_in, sync_ff, sync_in;
   logic [15:0] run_ff, run_in, rcv_ff, rcv_in;
   logic [16:0] tick_ff, tick_in;
   logic [7:0]  att_ff, att_in, err_ff, err_in, retr_ff, retr_in;
   logic [23:0] total_ff, total_in;

   // step outputs
   xmr_pkg::res_type res_d [3];
   logic [1:0]  res_n;
   logic        accept;
   logic [2:0]  q_count;
   xmr_pkg::res_type q_head;
   logic        q_valid;

   // step helpers
   logic [16:0] rt;
   logic [17:0] two_rt;
   logic [10:0] bs;
   logic [15:0] calc;
   logic [24:0] tsum;
   logic [1:0]  ev;
   logic        attempt;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (q_count <= 3'd1);
   assign rt         = (rto_ff == 16'd0) ? 17'd1 : {1'b0, rto_ff};
   assign two_rt     = {rt, 1'b0};

   // one request: next state and up to three results
   always_comb begin
      phase_in = phase_ff; af_in = af_ff; exp_in = exp_ff; got_in = got_ff;
      cnt_in = cnt_ff; long_in = long_ff; sync_in = sync_ff; run_in = run_ff;
      rcv_in = rcv_ff; tick_in = tick_ff; att_in = att_ff; err_in = err_ff;
      retr_in = retr_ff; total_in = total_ff;
      res_n = 2'd0; attempt = 1'b0; ev = xmr_pkg::EV_NONE; tsum = '0;
      bs = long_ff ? xmr_pkg::LONG_BLOCK : xmr_pkg::SHORT_BLOCK;
      calc = (mode_ff != xmr_pkg::MODE_SUM) ? run_ff : {8'h00, run_ff[7:0]};
      for (int i = 0; i < 3; i++) res_d[i] = '0;

      case (req_tuser)
         xmr_pkg::REQ_START: begin
            exp_in = 8'd1; got_in = '0; cnt_in = '0; long_in = 1'b0;
            run_in = '0; rcv_in = '0; tick_in = '0; att_in = '0; err_in = '0;
            retr_in = mretr_ff; sync_in = 1'b1; af_in = xmr_pkg::AF_NONE;
            total_in = '0;
            attempt = 1'b1;
         end
         xmr_pkg::REQ_BYTE: begin
            tick_in = '0;
            case (phase_ff)
               xmr_pkg::PH_SYNC: begin
                  if (req_tdata == xmr_pkg::CH_SOH || req_tdata == xmr_pkg::CH_STX) begin
                     long_in  = (req_tdata == xmr_pkg::CH_STX);
                     sync_in  = 1'b0;
                     phase_in = xmr_pkg::PH_BLKNO;
                  end else if (req_tdata == xmr_pkg::CH_EOT) begin
                     res_d[0].tx_valid = 1'b1;
                     res_d[0].tx_byte  = xmr_pkg::CH_ACK;
                     res_d[0].status   = xmr_pkg::ST_DONE;
                     res_n    = 2'd1;
                     phase_in = xmr_pkg::PH_IDLE;
                  end else if (req_tdata == xmr_pkg::CH_CAN) begin
                     phase_in = xmr_pkg::PH_CANWAIT;
                  end else begin
                     if (att_ff != 8'hFF) att_in = att_ff + 8'd1;
                     attempt = 1'b1;
                  end
               end
               xmr_pkg::PH_CANWAIT: begin
                  if (req_tdata == xmr_pkg::CH_CAN) begin
                     phase_in = xmr_pkg::PH_FLUSH; af_in = xmr_pkg::AF_ACK_CANCEL;
                  end else begin
                     if (att_ff != 8'hFF) att_in = att_ff + 8'd1;
                     attempt = 1'b1;
                  end
               end
               xmr_pkg::PH_BLKNO: begin
                  got_in   = req_tdata;
                  phase_in = xmr_pkg::PH_BLKCMP;
               end
               xmr_pkg::PH_BLKCMP: begin
                  if (got_ff != ~req_tdata ||
                      (got_ff != exp_ff && got_ff != exp_ff - 8'd1)) begin
                     res_d[0].packet_event = xmr_pkg::EV_REJ;
                     res_d[0].block_length = bs;
                     res_n    = 2'd1;
                     phase_in = xmr_pkg::PH_FLUSH;
                     af_in    = (err_ff > merr_ff) ? xmr_pkg::AF_CAN_ERRORS
                                                   : xmr_pkg::AF_NAK;
                     if (err_ff != 8'hFF) err_in = err_ff + 8'd1;
                  end else begin
                     cnt_in = '0; run_in = '0; phase_in = xmr_pkg::PH_DATA;
                  end
               end
               xmr_pkg::PH_DATA: begin
                  res_d[0].payload_valid = 1'b1;
                  res_d[0].payload_byte  = req_tdata;
                  res_d[0].payload_index = cnt_ff[9:0];
                  res_n  = 2'd1;
                  run_in = (mode_ff != xmr_pkg::MODE_SUM)
                           ? xmr_pkg::crc_byte(run_ff, req_tdata)
                           : {8'h00, run_ff[7:0] + req_tdata};
                  cnt_in = cnt_ff + 11'd1;
                  if (cnt_in >= bs) phase_in = xmr_pkg::PH_CHK1;
               end
               xmr_pkg::PH_CHK1, xmr_pkg::PH_CHK2: begin
                  if (phase_ff == xmr_pkg::PH_CHK1) rcv_in = {8'h00, req_tdata};
                  else rcv_in = {rcv_ff[7:0], req_tdata};
                  if (phase_ff == xmr_pkg::PH_CHK1 && mode_ff != xmr_pkg::MODE_SUM) begin
                     phase_in = xmr_pkg::PH_CHK2;
                  end else if (calc != rcv_in) begin
                     // bad check: reject
                     res_d[0].packet_event = xmr_pkg::EV_REJ;
                     res_d[0].block_length = bs;
                     res_n    = 2'd1;
                     phase_in = xmr_pkg::PH_FLUSH;
                     af_in    = (err_ff > merr_ff) ? xmr_pkg::AF_CAN_ERRORS
                                                   : xmr_pkg::AF_NAK;
                     if (err_ff != 8'hFF) err_in = err_ff + 8'd1;
                  end else begin
                     if (got_ff == exp_ff) begin
                        tsum     = {1'b0, total_ff} + {14'd0, bs};
                        total_in = tsum[24] ? xmr_pkg::TOTAL_MAX : tsum[23:0];
                        exp_in   = exp_ff + 8'd1;
                        retr_in  = mretr_ff;
                        ev       = xmr_pkg::EV_NEW;
                     end else begin
                        ev = xmr_pkg::EV_DUP;
                     end
                     res_d[0].packet_event = ev;
                     res_d[0].block_length = bs;
                     res_d[0].total_length = total_in;
                     res_n = 2'd1;
                     if (retr_in <= 8'd1) begin
                        retr_in  = '0;
                        phase_in = xmr_pkg::PH_FLUSH;
                        af_in    = xmr_pkg::AF_CAN_RETRANS;
                     end else begin
                        retr_in = retr_in - 8'd1;
                        res_d[0].tx_valid = 1'b1;
                        res_d[0].tx_byte  = xmr_pkg::CH_ACK;
                        att_in  = '0;
                        attempt = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         xmr_pkg::REQ_TICK: begin
            if (phase_ff != xmr_pkg::PH_IDLE) begin
               if (tick_ff != 17'h1FFFF) tick_in = tick_ff + 17'd1;
               if (phase_ff == xmr_pkg::PH_FLUSH) begin
                  if ({1'b0, tick_in} >= two_rt) begin
                     af_in = xmr_pkg::AF_NONE;
                     res_d[0].tx_valid = 1'b1;
                     case (af_ff)
                        xmr_pkg::AF_NAK: begin
                           res_d[0].tx_byte = xmr_pkg::CH_NAK;
                           res_n   = 2'd1;
                           att_in  = '0;
                           attempt = 1'b1;
                        end
                        xmr_pkg::AF_ACK_CANCEL: begin
                           res_d[0].tx_byte = xmr_pkg::CH_ACK;
                           res_d[0].status  = xmr_pkg::ST_CANCEL;
                           res_n    = 2'd1;
                           phase_in = xmr_pkg::PH_IDLE;
                        end
                        default: begin
                           for (int i = 0; i < 3; i++) begin
                              res_d[i].tx_valid = 1'b1;
                              res_d[i].tx_byte  = xmr_pkg::CH_CAN;
                           end
                           res_d[2].status =
                              (af_ff == xmr_pkg::AF_CAN_SYNC)    ? xmr_pkg::ST_SYNC :
                              (af_ff == xmr_pkg::AF_CAN_RETRANS) ? xmr_pkg::ST_RETRANS
                                                                 : xmr_pkg::ST_ERRORS;
                           res_n    = 2'd3;
                           phase_in = xmr_pkg::PH_IDLE;
                        end
                     endcase
                  end
               end else if (tick_in >= rt) begin
                  tick_in = '0;
                  if (phase_ff == xmr_pkg::PH_SYNC) begin
                     if (att_ff != 8'hFF) att_in = att_ff + 8'd1;
                     attempt = 1'b1;
                  end else if (phase_ff == xmr_pkg::PH_CANWAIT) begin
                     phase_in = xmr_pkg::PH_FLUSH; af_in = xmr_pkg::AF_ACK_CANCEL;
                  end else begin
                     // timeout inside a block: reject
                     res_d[0].packet_event = xmr_pkg::EV_REJ;
                     res_d[0].block_length = bs;
                     res_n    = 2'd1;
                     phase_in = xmr_pkg::PH_FLUSH;
                     af_in    = (err_ff > merr_ff) ? xmr_pkg::AF_CAN_ERRORS
                                                   : xmr_pkg::AF_NAK;
                     if (err_ff != 8'hFF) err_in = err_ff + 8'd1;
                  end
               end
            end
         end
         default: ;
      endcase

      // new header attempt: sync character or give up
      if (attempt) begin
         tick_in = '0;
         if (att_in >= msync_ff) begin
            phase_in = xmr_pkg::PH_FLUSH;
            af_in    = xmr_pkg::AF_CAN_SYNC;
         end else begin
            phase_in = xmr_pkg::PH_SYNC;
            if (sync_in) begin
               res_d[res_n].tx_valid = 1'b1;
               res_d[res_n].tx_byte  = (mode_ff == xmr_pkg::MODE_SUM) ? xmr_pkg::CH_NAK :
                                       (mode_ff == xmr_pkg::MODE_1KG) ? xmr_pkg::CH_G
                                                                      : xmr_pkg::CH_C;
               res_n = res_n + 2'd1;
            end
         end
      end

      // totals and last flags
      for (int i = 0; i < 3; i++) begin
         res_d[i].total_length = total_in;
         res_d[i].last         = (2'(i) == res_n - 2'd1);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 2'd2;
         rto_ff   <= 16'd1000;
         msync_ff <= 8'd10;
         mretr_ff <= 8'd10;
         merr_ff  <= 8'd10;
      end else if (csr_we) begin
         case (csr_addr)
            xmr_pkg::CSR_MODE:    mode_ff  <= csr_wdata[1:0];
            xmr_pkg::CSR_TIMEOUT: rto_ff   <= csr_wdata;
            xmr_pkg::CSR_SYNC:    msync_ff <= csr_wdata[7:0];
            xmr_pkg::CSR_RETRANS: mretr_ff <= csr_wdata[7:0];
            xmr_pkg::CSR_ERRORS:  merr_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // protocol state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xmr_pkg::PH_IDLE; af_ff <= xmr_pkg::AF_NONE;
         exp_ff <= 8'd1; got_ff <= '0; cnt_ff <= '0; long_ff <= 1'b0;
         sync_ff <= 1'b1; run_ff <= '0; rcv_ff <= '0; tick_ff <= '0;
         att_ff <= '0; err_ff <= '0; retr_ff <= 8'd10; total_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in; af_ff <= af_in; exp_ff <= exp_in; got_ff <= got_in;
         cnt_ff <= cnt_in; long_ff <= long_in; sync_ff <= sync_in;
         run_ff <= run_in; rcv_ff <= rcv_in; tick_ff <= tick_in;
         att_ff <= att_in; err_ff <= err_in; retr_ff <= retr_in;
         total_ff <= total_in;
      end
   end

   xmr_res_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (accept ? res_n : 2'd0),
      .push_data (res_d),
      .pop       (rsp_tready),
      .head      (q_head),
      .not_empty (q_valid),
      .count     (q_count)
   );

   assign rsp_tvalid = q_valid;
   assign rsp_tlast  = q_head.last;
   assign rsp_tdata  = {4'b0000, q_head.status, q_head.total_length, q_head.block_length,
                        q_head.packet_event, q_head.payload_index, q_head.payload_byte,
                        q_head.payload_valid, q_head.tx_byte, q_head.tx_valid};

   // checks
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == xmr_pkg::PH_IDLE && req_tuser == xmr_pkg::REQ_BYTE)
      |-> res_n == 2'd0)
      else $error("byte while idle produced a result");

   a_flush_action: assert property (@(posedge clock) disable iff (reset)
      phase_ff == xmr_pkg::PH_FLUSH |-> af_ff != xmr_pkg::AF_NONE)
      else $error("flush without a pending action");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (phase_ff == xmr_pkg::PH_IDLE && exp_ff == 8'd1 && q_count == 3'd0))
      else $error("state not cleared by reset");

   a_room: assert property (@(posedge clock) disable iff (reset)
      accept |=> q_count <= 3'd4)
      else $error("result queue overflow");

endmodule
`default_nettype wire

>>> verif/tb.sv
// tb: self-checking testbench for xmodem_receiver_unit.
// Depends on xmr_pkg and the receiver RTL; drives directed and random
// line traffic and checks every result against an in-bench protocol model or, for typed directed rows, a given result.
`timescale 1ns / 1ps
module tb;
   import xmr_pkg::*;

   // Result fields, first field of rsp_tdata first
   typedef struct packed {
      logic        txv;
      logic [7:0]  txb;
      logic        pv;
      logic [7:0]  pb;
      logic [9:0]  pidx;
      logic [1:0]  ev;
      logic [10:0] blen;
      logic [23:0] total;
      logic [2:0]  st;
      logic        last;
   } res_t;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] value;
      bit         typed;
      res_t       want;
   } row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic [1:0]  req_tuser = REQ_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = CSR_MODE;
   logic [15:0] csr_wdata = 16'h0000;

   xmodem_receiver_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Protocol model: configuration and state
   // ---------------------------------------------------------------
   logic [1:0]  cfg_mode = MODE_1K;
   logic [15:0] cfg_rt = 16'd1000;
   logic [7:0]  cfg_sync = 8'd10, cfg_retrans = 8'd10, cfg_errors = 8'd10;

   phase_type   ph = PH_IDLE;
   flush_type   pending = AF_NONE;
   logic [7:0]  exp_blk = 8'd1, got_blk = 8'd0, attempts = 8'd0, errs = 8'd0;
   logic [7:0]  retrans = 8'd10;
   logic [10:0] nbytes = 11'd0;
   logic        is_long = 1'b0, sync_on = 1'b1;
   logic [15:0] run_chk = 16'h0, rcv_chk = 16'h0;
   logic [16:0] ticks = 17'd0;
   logic [23:0] total = 24'd0;

   res_t step_out[$];
   res_t rsp_due[$];

   int faults = 0, results_seen = 0, items_sent = 0, blocks_good = 0;
   bit calm = 1'b0, squeeze = 1'b0, allow_long = 1'b0;

   function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         x = x[15] ? ({x[14:0], 1'b0} ^ 16'h1021) : {x[14:0], 1'b0};
      return x;
   endfunction

   function automatic int rt_eff();
      return (cfg_rt == 16'd0) ? 1 : int'(cfg_rt);
   endfunction

   function automatic logic [10:0] blk_size();
      return is_long ? LONG_BLOCK : SHORT_BLOCK;
   endfunction

   function automatic void put_result(logic txv, logic [7:0] txb, logic pv, logic [7:0] pb,
                                      logic [9:0] pidx, logic [1:0] ev, logic [10:0] blen,
                                      logic [2:0] st);
      res_t r;
      if (step_out.size() >= 3) return;
      r = '{txv, txb, pv, pb, pidx, ev, blen, total, st, 1'b0};
      step_out.push_back(r);
   endfunction

   function automatic void start_flush(flush_type a);
      pending = a;
      ph = PH_FLUSH;
      ticks = 17'd0;
   endfunction

   function automatic void enter_attempt();
      logic [7:0] sc;
      if (attempts >= cfg_sync) begin
         start_flush(AF_CAN_SYNC);
         return;
      end
      sc = (cfg_mode == MODE_SUM) ? CH_NAK : ((cfg_mode == MODE_1KG) ? CH_G : CH_C);
      if (sync_on) put_result(1'b1, sc, 0, 0, 0, EV_NONE, 0, ST_RUN);
      ph = PH_SYNC;
      ticks = 17'd0;
   endfunction

   function automatic void next_attempt();
      if (attempts < 8'd255) attempts++;
      enter_attempt();
   endfunction

   function automatic void reject_block();
      put_result(0, 0, 0, 0, 0, EV_REJ, blk_size(), ST_RUN);
      start_flush(errs > cfg_errors ? AF_CAN_ERRORS : AF_NAK);
      if (errs < 8'd255) errs++;
   endfunction

   function automatic void judge_block();
      logic [15:0] calc;
      logic [1:0]  ev;
      logic [24:0] sum;
      calc = (cfg_mode != MODE_SUM) ? run_chk : {8'h00, run_chk[7:0]};
      if (calc != rcv_chk) begin
         reject_block();
         return;
      end
      if (got_blk == exp_blk) begin
         sum = total + blk_size();
         total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[23:0];
         exp_blk++;
         retrans = cfg_retrans;
         ev = EV_NEW;
      end else begin
         ev = EV_DUP;
      end
      if (retrans <= 8'd1) begin
         retrans = 8'd0;
         put_result(0, 0, 0, 0, 0, ev, blk_size(), ST_RUN);
         start_flush(AF_CAN_RETRANS);
         return;
      end
      retrans--;
      put_result(1'b1, CH_ACK, 0, 0, 0, ev, blk_size(), ST_RUN);
      attempts = 8'd0;
      enter_attempt();
   endfunction

   function automatic void finish_flush();
      flush_type a;
      logic [2:0] st;
      a = pending;
      pending = AF_NONE;
      if (a == AF_NAK) begin
         put_result(1'b1, CH_NAK, 0, 0, 0, EV_NONE, 0, ST_RUN);
         attempts = 8'd0;
         enter_attempt();
      end else if (a == AF_ACK_CANCEL) begin
         put_result(1'b1, CH_ACK, 0, 0, 0, EV_NONE, 0, ST_CANCEL);
         ph = PH_IDLE;
      end else begin
         st = (a == AF_CAN_SYNC) ? ST_SYNC : ((a == AF_CAN_RETRANS) ? ST_RETRANS : ST_ERRORS);
         put_result(1'b1, CH_CAN, 0, 0, 0, EV_NONE, 0, ST_RUN);
         put_result(1'b1, CH_CAN, 0, 0, 0, EV_NONE, 0, ST_RUN);
         put_result(1'b1, CH_CAN, 0, 0, 0, EV_NONE, 0, st);
         ph = PH_IDLE;
      end
   endfunction

   function automatic void take_byte(logic [7:0] b);
      ticks = 17'd0;
      case (ph)
         PH_SYNC: begin
            if (b == CH_SOH || b == CH_STX) begin
               is_long = (b == CH_STX);
               sync_on = 1'b0;
               ph = PH_BLKNO;
            end else if (b == CH_EOT) begin
               put_result(1'b1, CH_ACK, 0, 0, 0, EV_NONE, 0, ST_DONE);
               ph = PH_IDLE;
            end else if (b == CH_CAN) begin
               ph = PH_CANWAIT;
            end else begin
               next_attempt();
            end
         end
         PH_CANWAIT: begin
            if (b == CH_CAN) start_flush(AF_ACK_CANCEL);
            else next_attempt();
         end
         PH_BLKNO: begin
            got_blk = b;
            ph = PH_BLKCMP;
         end
         PH_BLKCMP: begin
            if (got_blk != ~b || (got_blk != exp_blk && got_blk != exp_blk - 8'd1)) begin
               reject_block();
            end else begin
               nbytes = 11'd0;
               run_chk = 16'h0;
               ph = PH_DATA;
            end
         end
         PH_DATA: begin
            put_result(0, 0, 1'b1, b, nbytes[9:0], EV_NONE, 0, ST_RUN);
            if (cfg_mode != MODE_SUM) run_chk = crc_step(run_chk, b);
            else run_chk = {8'h00, run_chk[7:0] + b};
            nbytes++;
            if (nbytes >= blk_size()) ph = PH_CHK1;
         end
         PH_CHK1: begin
            rcv_chk = {8'h00, b};
            if (cfg_mode != MODE_SUM) ph = PH_CHK2;
            else judge_block();
         end
         PH_CHK2: begin
            rcv_chk = {rcv_chk[7:0], b};
            judge_block();
         end
         default: ;
      endcase
   endfunction

   function automatic void take_tick();
      if (ph == PH_IDLE) return;
      if (ticks < 17'h1FFFF) ticks++;
      if (ph == PH_FLUSH) begin
         if (int'(ticks) >= 2 * rt_eff()) finish_flush();
         return;
      end
      if (int'(ticks) < rt_eff()) return;
      ticks = 17'd0;
      if (ph == PH_SYNC) next_attempt();
      else if (ph == PH_CANWAIT) start_flush(AF_ACK_CANCEL);
      else reject_block();
   endfunction

   // Work out the results of one accepted request into step_out
   function automatic void predict_request(logic [1:0] kind, logic [7:0] b);
      step_out.delete();
      if (kind == REQ_START) begin
         exp_blk = 8'd1; got_blk = 8'd0; nbytes = 11'd0; is_long = 1'b0;
         run_chk = 16'h0; rcv_chk = 16'h0; ticks = 17'd0; attempts = 8'd0;
         errs = 8'd0; retrans = cfg_retrans; sync_on = 1'b1; pending = AF_NONE;
         total = 24'd0;
         enter_attempt();
      end else if (kind == REQ_BYTE) begin
         take_byte(b);
      end else if (kind == REQ_TICK) begin
         take_tick();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   task automatic offer_request(input logic [1:0] kind, input logic [7:0] b,
                                input bit typed = 1'b0, input res_t want = '0);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_request(kind, b);
      if (typed) rsp_due.push_back(want);
      else foreach (step_out[i]) rsp_due.push_back(step_out[i]);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      offer_request(REQ_BYTE, b);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) offer_request(REQ_TICK, 8'($urandom));
   endtask

   // One register write, then the write enable is dropped before the task returns
   task automatic write_csr(input logic [2:0] idx, input logic [15:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MODE:    cfg_mode = v[1:0];
         CSR_TIMEOUT: cfg_rt = v;
         CSR_SYNC:    cfg_sync = v[7:0];
         CSR_RETRANS: cfg_retrans = v[7:0];
         CSR_ERRORS:  cfg_errors = v[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic [1:0] m, input logic [15:0] rt, input logic [7:0] sy,
                             input logic [7:0] re, input logic [7:0] er);
      write_csr(CSR_MODE, {14'd0, m});
      write_csr(CSR_TIMEOUT, rt);
      write_csr(CSR_SYNC, {8'd0, sy});
      write_csr(CSR_RETRANS, {8'd0, re});
      write_csr(CSR_ERRORS, {8'd0, er});
   endtask

   // Drain all results; flush/tick requests may give none, so allow a margin
   task automatic settle();
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // One framed block with random content, sometimes flawed on purpose;
   // when the item budget is short only a header that is turned away goes out
   task automatic send_block(input bit want_long, input int room);
      logic [7:0]  no, d;
      logic [15:0] chk;
      int n, flaw, need;
      n = want_long ? 1024 : 128;
      need = n + 5 + ((ph != PH_SYNC) ? 2 * rt_eff() + 1 : 0);
      if (ph == PH_FLUSH || ph != PH_SYNC) send_ticks(2 * rt_eff() + 1);
      flaw = (room < need) ? $urandom_range(0, 1) : $urandom_range(0, 9);
      no = ($urandom_range(0, 5) == 0) ? exp_blk - 8'd1 : exp_blk;
      if (flaw == 1) no = exp_blk + 8'd1 + 8'($urandom_range(0, 200));
      send_byte(want_long ? CH_STX : CH_SOH);
      send_byte(no);
      send_byte(flaw == 0 ? ~no ^ (8'd1 << $urandom_range(0, 7)) : ~no);
      if (flaw <= 1) return;
      chk = 16'h0;
      for (int i = 0; i < n; i++) begin
         d = 8'($urandom);
         chk = (cfg_mode != MODE_SUM) ? crc_step(chk, d) : {8'h00, chk[7:0] + d};
         send_byte(d);
         if (flaw == 3 && i == n / 2) begin
            send_ticks(rt_eff());
            return;
         end
      end
      if (flaw == 2) chk ^= 16'h1 << $urandom_range(0, 7);
      if (cfg_mode != MODE_SUM) send_byte(chk[15:8]);
      send_byte(chk[7:0]);
   endtask

   // Mostly well-formed transfers, with line noise, timeouts and cancels
   task automatic random_traffic(input int quota);
      int stop;
      stop = items_sent + quota;
      while (items_sent < stop) begin
         if (ph == PH_IDLE && $urandom_range(0, 4) != 0) begin
            offer_request(REQ_START, 8'($urandom));
         end else begin
            case ($urandom_range(0, 15))
               0: offer_request(REQ_START, 8'($urandom));
               1, 2, 3, 4, 5, 6, 7: begin
                  send_block(allow_long && $urandom_range(0, 1) == 0, stop - items_sent);
                  if (is_long) allow_long = 1'b0;
               end
               8: send_byte(CH_EOT);
               9: begin
                  send_byte(CH_CAN);
                  if ($urandom_range(0, 1) == 0) send_byte(CH_CAN);
                  else send_ticks(rt_eff());
               end
               10, 11, 12: send_ticks($urandom_range(1, 2 * rt_eff() + 2));
               default: repeat ($urandom_range(1, 3))
                           offer_request(2'($urandom), 8'($urandom));
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Result side: random stalls plus one long hold-off
   // ---------------------------------------------------------------
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_tready <= 1'b0;
            hold = 0;
            while (hold < 400) begin
               @(negedge clock);
               hold++;
            end
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      res_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[9], rsp_tdata[17:10],
                 rsp_tdata[27:18], rsp_tdata[29:28], rsp_tdata[40:30], rsp_tdata[64:41],
                 rsp_tdata[67:65], rsp_tlast};
         results_seen++;
         if (rsp_due.size() == 0) begin
            faults++;
            if (faults <= 10) $display("unexpected result: %p", got);
         end else begin
            want = rsp_due.pop_front();
            if (got.ev == EV_NEW && want.ev == EV_NEW) blocks_good++;
            if (got !== want) begin
               faults++;
               if (faults <= 10) begin
                  $display("mismatch at result %0d:", results_seen);
                  $display("  exp tx %b/%h pay %b/%h@%0d ev %0d len %0d tot %0d st %0d last %b",
                           want.txv, want.txb, want.pv, want.pb, want.pidx, want.ev,
                           want.blen, want.total, want.st, want.last);
                  $display("  got tx %b/%h pay %b/%h@%0d ev %0d len %0d tot %0d st %0d last %b",
                           got.txv, got.txb, got.pv, got.pb, got.pidx, got.ev,
                           got.blen, got.total, got.st, got.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   function automatic res_t ctl(logic [7:0] txb, logic [2:0] st);
      return '{1'b1, txb, 1'b0, 8'h00, 10'd0, EV_NONE, 11'd0, 24'd0, st, 1'b1};
   endfunction

   initial begin
      row_t rows[$];
      res_t rej;
      rej = '{1'b0, 8'h00, 1'b0, 8'h00, 10'd0, EV_REJ, SHORT_BLOCK, 24'd0, ST_RUN, 1'b1};
      // idle traffic and unused kind, then sync, noise, cancel, EOT, restarts
      rows = '{
         '{REQ_TICK, 8'h00, 0, '0}, '{REQ_BYTE, 8'hFF, 0, '0}, '{2'd3, 8'hA5, 0, '0},
         '{REQ_START, 8'h00, 1, ctl(CH_C, ST_RUN)}, '{REQ_BYTE, 8'h00, 1, ctl(CH_C, ST_RUN)},
         '{REQ_BYTE, CH_CAN, 0, '0}, '{REQ_BYTE, 8'h55, 1, ctl(CH_C, ST_RUN)},
         '{REQ_BYTE, CH_EOT, 1, ctl(CH_ACK, ST_DONE)},
         '{REQ_START, 8'hFF, 1, ctl(CH_C, ST_RUN)}, '{REQ_BYTE, CH_STX, 0, '0},
         '{REQ_BYTE, 8'h01, 0, '0}, '{REQ_BYTE, 8'hFE, 0, '0}, '{REQ_BYTE, 8'h00, 0, '0},
         '{REQ_BYTE, 8'hFF, 0, '0}, '{REQ_BYTE, 8'h80, 0, '0},
         '{REQ_START, 8'h00, 1, ctl(CH_C, ST_RUN)}, '{REQ_BYTE, CH_SOH, 0, '0},
         '{REQ_BYTE, 8'h05, 0, '0}, '{REQ_BYTE, 8'hFA, 1, rej},
         '{REQ_BYTE, CH_CAN, 0, '0}, '{REQ_BYTE, 8'h7F, 0, '0},
         '{REQ_START, 8'h00, 1, ctl(CH_C, ST_RUN)}, '{REQ_BYTE, CH_CAN, 0, '0},
         '{REQ_BYTE, CH_CAN, 0, '0}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) offer_request(rows[i].kind, rows[i].value, rows[i].typed, rows[i].want);
      settle();

      // CRC, short timeout; long receiver hold-off early on
      set_config(MODE_CRC, 16'd3, 8'd4, 8'd10, 8'd3);
      squeeze = 1'b1;
      random_traffic(150);
      settle();

      // checksum mode, timeout of 1, sync, retransmit and error limits at their top
      set_config(MODE_SUM, 16'd1, 8'd255, 8'd255, 8'd255);
      random_traffic(25);
      settle();

      // 1K-G with the tightest limits
      set_config(MODE_1KG, 16'd2, 8'd0, 8'd1, 8'd0);
      random_traffic(15);
      settle();
      write_csr(CSR_SYNC, 16'd2);
      random_traffic(15);
      settle();

      // 1K CRC, zero timeout, long headers allowed; no idling towards the end
      set_config(MODE_1K, 16'd0, 8'd1, 8'd2, 8'd1);
      allow_long = 1'b1;
      random_traffic(15);
      calm = 1'b1;
      random_traffic(15);
      settle();

      // longest timeout: start and a little traffic only
      set_config(MODE_1KG, 16'hFFFF, 8'd255, 8'd10, 8'd10);
      offer_request(REQ_START, 8'h00);
      send_ticks(5);
      send_byte(8'h33);
      settle();

      repeat (20) @(negedge clock);
      $display("Sent %0d requests over six register settings; %0d results checked, %0d new blocks.",
               items_sent, results_seen, blocks_good);
      $display("Mismatches: %0d, results still outstanding: %0d.", faults, rsp_due.size());
      if (faults == 0 && rsp_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #8000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
